// File: hw/rtl/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Field widths of the transaction ports
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Default list depth
    localparam int DEF_CAPACITY = 16;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_DUMP      = 3'd7
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec_op;     // run the accepted operation as one result
        logic dump_start;  // rewind the dump pointer
        logic dump_step;   // emit one entry of a dump
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic list_empty;  // count is zero
        logic dump_last;   // dump pointer sits on the last entry
    } dp_status_t;

endpackage : ple_pkg
`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with positional edits.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction (operation, item_value, position) is taken at a rising edge
//   with start high and busy low.
//   Results come out on status/out_value/entry_count/last_of_run, each valid
//   for exactly one cycle while result_valid is high; the receiver always
//   takes them and cannot stall the block.
//   Inserts, deletes, clear and a dump of an empty list give one result in
//   the cycle after acceptance, with last_of_run set; busy stays low, so one
//   such transaction per cycle is taken.
//   A dump of n entries raises busy and streams one entry per cycle,
//   front first; the rate is set by the single read port on the entry
//   cells, and the last result carries last_of_run. The next transaction
//   can be taken in the cycle the last dump result is shown.
//   Edits shift all entry cells from the edit position on together.
//   Reset empties the list (count zero) and drops any dump in progress;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ple_pkg::OP_W-1:0]           operation,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] item_value,
    input  wire logic [ple_pkg::POS_W-1:0]          position,
    output logic                                    result_valid,
    output logic [ple_pkg::STATUS_W-1:0]            status,
    output logic signed [ple_pkg::VALUE_W-1:0]      out_value,
    output logic [ple_pkg::COUNT_W-1:0]             entry_count,
    output logic                                    last_of_run
);
    import ple_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Sequence transactions and dumps
    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Hold the list and drive results
    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .operation    (operation),
        .item_value   (item_value),
        .position     (position),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .status       (status),
        .out_value    (out_value),
        .entry_count  (entry_count),
        .last_of_run  (last_of_run)
    );

endmodule : positional_list_engine
`default_nettype wire

// File: hw/rtl/ple_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller: accepts transactions and sequences dumps one entry per cycle.
// ----------------------------------------------------------------------------
module ple_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ple_pkg::OP_W-1:0]      operation,
    input  wire ple_pkg::dp_status_t           dp_status,
    output ple_pkg::ctrl_cmd_t                 cmd,
    output logic                               busy
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Decode the next state and the datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((op_t'(operation) == OP_DUMP) && !dp_status.list_empty)
                    begin
                        cmd.dump_start = 1'b1;
                        state_next     = S_DUMP;
                    end
                    else
                    begin
                        cmd.exec_op = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                cmd.dump_step = 1'b1;
                if (dp_status.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : ple_ctrl
`default_nettype wire

// File: hw/rtl/ple_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_datapath
// Row of shifting entry cells, the count, the dump pointer and the result
// registers.
// ----------------------------------------------------------------------------
module ple_datapath #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ple_pkg::ctrl_cmd_t                cmd,
    input  wire logic [ple_pkg::OP_W-1:0]          operation,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] item_value,
    input  wire logic [ple_pkg::POS_W-1:0]         position,
    output ple_pkg::dp_status_t                    dp_status,
    output logic                                   result_valid,
    output logic [ple_pkg::STATUS_W-1:0]           status,
    output logic signed [ple_pkg::VALUE_W-1:0]     out_value,
    output logic [ple_pkg::COUNT_W-1:0]            entry_count,
    output logic                                   last_of_run
);
    import ple_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // List storage and control
    logic [VALUE_W-1:0] entries_reg   [CAPACITY];
    logic [VALUE_W-1:0] entries_next  [CAPACITY];
    logic [VALUE_W-1:0] from_prev     [CAPACITY];
    logic [VALUE_W-1:0] from_next     [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   dump_idx_reg;
    logic [IDX_W-1:0]   dump_idx_next;

    // Result registers
    logic                 valid_reg;
    logic                 valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [VALUE_W-1:0]   value_reg;
    logic [VALUE_W-1:0]   value_next;
    logic [COUNT_W-1:0]   ecount_reg;
    logic [COUNT_W-1:0]   ecount_next;
    logic                 last_reg;
    logic                 last_next;

    // Edit decode
    op_t                op;
    logic [IDX_W-1:0]   edit_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [VALUE_W-1:0] rd_data;
    logic               ins_en;
    logic               del_en;
    logic               clr_en;
    status_t            edit_status;
    logic               list_full;
    logic               pos_bad;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;

    assign op        = op_t'(operation);
    assign list_full = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);

    assign dp_status.list_empty = (count_reg == '0);
    assign dp_status.dump_last  = ((CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg);

    // Neighbor taps of each cell
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_tap
        if (g == 0)
        begin : g_first
            assign from_prev[g] = '0;
        end
        else
        begin : g_mid_prev
            assign from_prev[g] = entries_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign from_next[g] = entries_reg[g];
        end
        else
        begin : g_mid_next
            assign from_next[g] = entries_reg[g+1];
        end
    end

    // Select the entry that leaves the list or streams out
    assign rd_idx  = cmd.dump_step ? dump_idx_reg : edit_idx;
    assign rd_data = entries_reg[rd_idx];

    // Decode the operation into a cell action and a status
    always_comb
    begin
        ins_en      = 1'b0;
        del_en      = 1'b0;
        clr_en      = 1'b0;
        edit_idx    = '0;
        edit_status = ST_OK;
        case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                if (list_full)
                begin
                    edit_status = ST_FULL;
                end
                else if (op == OP_INS_FRONT)
                begin
                    ins_en = 1'b1;
                end
                else if (op == OP_INS_BACK)
                begin
                    ins_en   = 1'b1;
                    edit_idx = IDX_W'(count_reg);
                end
                else if (dp_status.list_empty)
                begin
                    edit_status = ST_EMPTY;
                end
                else if (pos_bad)
                begin
                    edit_status = ST_BAD_POS;
                end
                else
                begin
                    ins_en   = 1'b1;
                    edit_idx = IDX_W'(position - POS_W'(1));
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT:
            begin
                if (dp_status.list_empty)
                begin
                    edit_status = ST_EMPTY;
                end
                else if (op == OP_DEL_FRONT)
                begin
                    del_en = 1'b1;
                end
                else if (op == OP_DEL_BACK)
                begin
                    del_en   = 1'b1;
                    edit_idx = IDX_W'(count_reg - CNT_W'(1));
                end
                else if (pos_bad)
                begin
                    edit_status = ST_BAD_POS;
                end
                else
                begin
                    del_en   = 1'b1;
                    edit_idx = IDX_W'(position - POS_W'(1));
                end
            end
            OP_CLEAR:
            begin
                clr_en = 1'b1;
            end
            OP_DUMP:
            begin
                // only reaches here on an empty list
                edit_status = ST_EMPTY;
            end
            default:
            begin
                edit_status = ST_OK;
            end
        endcase
    end

    // Advance the cells, the count, the dump pointer and the result
    always_comb
    begin
        entries_next  = entries_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        valid_next    = 1'b0;
        status_next   = ST_OK;
        value_next    = '0;
        last_next     = 1'b1;

        if (cmd.exec_op)
        begin
            valid_next  = 1'b1;
            status_next = edit_status;
            if (ins_en)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (IDX_W'(i) == edit_idx)
                    begin
                        entries_next[i] = item_value;
                    end
                    else if (IDX_W'(i) > edit_idx)
                    begin
                        entries_next[i] = from_prev[i];
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end
            if (del_en)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (IDX_W'(i) >= edit_idx)
                    begin
                        entries_next[i] = from_next[i];
                    end
                end
                count_next = count_reg - CNT_W'(1);
                value_next = rd_data;
            end
            if (clr_en)
            begin
                count_next = '0;
            end
        end

        if (cmd.dump_start)
        begin
            dump_idx_next = '0;
        end

        if (cmd.dump_step)
        begin
            valid_next    = 1'b1;
            value_next    = rd_data;
            last_next     = dp_status.dump_last;
            dump_idx_next = dump_idx_reg + IDX_W'(1);
        end

        ecount_next = COUNT_W'(count_next);
    end

    // Hold the cells; each is written before it is ever read
    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    // Hold count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Hold dump pointer and result payload
    always_ff @(posedge clk)
    begin
        dump_idx_reg <= dump_idx_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        ecount_reg   <= ecount_next;
        last_reg     <= last_next;
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign out_value    = $signed(value_reg);
    assign entry_count  = ecount_reg;
    assign last_of_run  = last_reg;

endmodule : ple_datapath
`default_nettype wire

// File: hw/rtl/ple_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic [ple_pkg::OP_W-1:0]           operation,
    input wire logic                               result_valid,
    input wire logic [ple_pkg::STATUS_W-1:0]       status,
    input wire logic signed [ple_pkg::VALUE_W-1:0] out_value,
    input wire logic [ple_pkg::COUNT_W-1:0]        entry_count,
    input wire logic                               last_of_run
);
    import ple_pkg::*;

    // Every non-dump transaction gives exactly one result the next cycle
    a_edit_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op_t'(operation) != OP_DUMP))
        |=> (result_valid && last_of_run))
        else $error("edit transaction did not give a single result");

    // The final result of a transaction frees the block
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |-> !busy)
        else $error("busy still high at final result");

    // Only successful dump results come without the last mark
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> (status_t'(status) == ST_OK))
        else $error("non-final result with error status");

    // Failed edits return no value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status_t'(status) != ST_OK)) |-> (out_value == '0))
        else $error("error result with nonzero value");

    // A full rejection reports a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status_t'(status) == ST_FULL))
        |-> (entry_count == COUNT_W'(CAPACITY)))
        else $error("full status with count below capacity");

endmodule : ple_checker

bind positional_list_engine ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (.*);
`default_nettype wire
